/* rtl/x86_not_16bit_addressing_assert.svh */
// assertion macros shared by the checker of the not-instruction block
// no dependencies; clk and arst_n must be visible where a macro is used
`ifndef X86_NOT_16BIT_ADDRESSING_ASSERT_SVH
`define X86_NOT_16BIT_ADDRESSING_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define X86N_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("x86 not block assertion failed");

// next-cycle implication, disabled while in reset
`define X86N_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("x86 not block assertion failed");

`endif

/* rtl/x86not16_pkg.sv */
// shared types, codes and widths of the not-instruction block
// no dependencies; used by the top level, the ram wrapper users and the checker
`timescale 1ns / 1ps

package x86not16_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;

	// stream widths
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 120;
	localparam int OP_W        = 2;

	// item kinds carried in tuser
	localparam logic [OP_W-1:0] OP_NOT      = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_REG = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_MEM = 2'd2;

	// operand width codes
	localparam logic [1:0] WIDTH_BYTE  = 2'd0;
	localparam logic [1:0] WIDTH_WORD  = 2'd1;
	localparam logic [1:0] WIDTH_DWORD = 2'd2;

	// modrm mod field
	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;
	localparam logic [2:0] RM_DIRECT  = 3'd6;

	// register file
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BP = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SI = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DI = 3'd7;

	// byte memory split in four banks by the low address bits
	localparam int NUM_BANKS = 4;
	localparam int BANK_W    = 2;
	localparam int ROW_W     = 14;
	localparam int MEM_ROWS  = 16384;
	typedef logic [ROW_W-1:0] row_t;

	// operand mask for a width code
	function automatic word_t width_mask(input logic [1:0] width);
		word_t m;
		unique case (width)
			WIDTH_BYTE: m = 32'h0000_00ff;
			WIDTH_WORD: m = 32'h0000_ffff;
			default:    m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

endpackage

/* rtl/x86not16_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module x86not16_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port, read returns the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/x86_not_16bit_addressing.sv */
// NOT instruction with 16-bit addressing: the accept cycle decodes the ModRM byte, forms the
// effective address and reads four byte banks; the write-back stage then inverts the operand,
// writes the banks or the register file back and loads the result word into the output
// register; a NOT word waits there while a result word is stalled. One item is taken per cycle
// while results are drained; a result word passes the write-back stage and the output register,
// with forwarding covering a word that reads bytes the word before it is writing. After reset a
// clearing pass zeroes the 64 KB memory with input tready low. Load words produce no result.
// depends on x86not16_pkg and x86not16_ram
`timescale 1ns / 1ps

module x86_not_16bit_addressing
	import x86not16_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// width_bit, size_prefix, modrm_byte, displacement, load_reg_index, load_value,
	// load_address, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [OP_W-1:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// effective_address, operand_in_memory, operand_width, old_value, new_value, next_ip,
	// zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// input fields
	logic [OP_W-1:0]      in_op;
	logic                 in_w;
	logic                 in_pfx;
	logic [7:0]           in_modrm;
	logic [15:0]          in_disp;
	logic [REG_IDX_W-1:0] in_lreg;
	word_t                in_lval;
	logic [15:0]          in_laddr;

	assign in_op    = s_axis_tuser;
	assign in_w     = s_axis_tdata[0];
	assign in_pfx   = s_axis_tdata[1];
	assign in_modrm = s_axis_tdata[9:2];
	assign in_disp  = s_axis_tdata[25:10];
	assign in_lreg  = s_axis_tdata[28:26];
	assign in_lval  = s_axis_tdata[60:29];
	assign in_laddr = s_axis_tdata[76:61];

	// state registers
	word_t                rf_q [NUM_REGS];
	word_t                rf_d [NUM_REGS];
	word_t                ip_q;
	logic                 clr_busy_q;
	row_t                 clr_row_q;

	// write-back stage registers
	logic                 valid_s1;
	logic [OP_W-1:0]      op_s1;
	logic [1:0]           width_s1;
	logic                 inmem_s1;
	logic [2:0]           rm_s1;
	logic [15:0]          ea_s1;
	logic [2:0]           ilen_s1;
	logic [REG_IDX_W-1:0] lreg_s1;
	word_t                lval_s1;
	row_t                 row_s1      [NUM_BANKS];
	logic                 fwd_s1      [NUM_BANKS];
	byte_t                fwd_data_s1 [NUM_BANKS];

	// handshake
	logic in_acc;
	logic b_adv;

	assign b_adv = valid_s1 && ((op_s1 != OP_NOT) || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!valid_s1 || b_adv);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// decode and effective address, using the register file as it stands after write-back
	logic [1:0]  a_mod;
	logic [2:0]  a_rm;
	logic        a_direct;
	logic [15:0] a_base;
	logic [15:0] a_dsp;
	logic [15:0] a_ea;
	logic [2:0]  a_ilen;
	logic [1:0]  a_width;
	row_t        a_row [NUM_BANKS];

	assign a_mod    = in_modrm[7:6];
	assign a_rm     = in_modrm[2:0];
	assign a_direct = (a_mod == MOD_NODISP) && (a_rm == RM_DIRECT);

	always_comb begin
		unique case (a_rm)
			3'd0: a_base = rf_d[REG_BX][15:0] + rf_d[REG_SI][15:0];
			3'd1: a_base = rf_d[REG_BX][15:0] + rf_d[REG_DI][15:0];
			3'd2: a_base = rf_d[REG_BP][15:0] + rf_d[REG_SI][15:0];
			3'd3: a_base = rf_d[REG_BP][15:0] + rf_d[REG_DI][15:0];
			3'd4: a_base = rf_d[REG_SI][15:0];
			3'd5: a_base = rf_d[REG_DI][15:0];
			3'd6: a_base = rf_d[REG_BP][15:0];
			default: a_base = rf_d[REG_BX][15:0];
		endcase
		if (a_direct) begin
			a_base = 16'd0;
		end
	end

	// displacement and instruction length
	always_comb begin
		priority if (a_direct) begin
			a_dsp  = in_disp;
			a_ilen = 3'd4;
		end else if (a_mod == MOD_DISP8) begin
			a_dsp  = {{8{in_disp[7]}}, in_disp[7:0]};
			a_ilen = 3'd3;
		end else if (a_mod == MOD_DISP16) begin
			a_dsp  = in_disp;
			a_ilen = 3'd4;
		end else begin
			a_dsp  = 16'd0;
			a_ilen = 3'd2;
		end
	end

	assign a_ea = (in_op == OP_LOAD_MEM) ? in_laddr : a_base + a_dsp;
	assign a_width = !in_w ? WIDTH_BYTE : (in_pfx ? WIDTH_WORD : WIDTH_DWORD);

	// bank k holds the byte at row ea/4, or the next row when k lies below the start bank
	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			a_row[k] = a_ea[15:BANK_W]
				+ ((BANK_W'(k) < a_ea[BANK_W-1:0]) ? ROW_W'(1) : ROW_W'(0));
		end
	end

	// byte banks
	logic  bk_we    [NUM_BANKS];
	row_t  bk_waddr [NUM_BANKS];
	byte_t bk_wdata [NUM_BANKS];
	byte_t bk_rdata [NUM_BANKS];
	logic  b_we     [NUM_BANKS];
	byte_t b_wdata  [NUM_BANKS];

	for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
		x86not16_ram #(
			.WIDTH(8),
			.DEPTH(MEM_ROWS)
		) u_bank (
			.clk   (clk),
			.we    (bk_we[g]),
			.waddr (bk_waddr[g]),
			.wdata (bk_wdata[g]),
			.re    (in_acc),
			.raddr (a_row[g]),
			.rdata (bk_rdata[g])
		);
	end

	// clearing pass owns the write ports until it ends
	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			bk_we[k]    = clr_busy_q || b_we[k];
			bk_waddr[k] = clr_busy_q ? clr_row_q : row_s1[k];
			bk_wdata[k] = clr_busy_q ? 8'd0 : b_wdata[k];
		end
	end

	// write-back stage: gather the operand
	word_t                mask_s1;
	byte_t                rd_byte [NUM_BANKS];
	word_t                mem_word;
	logic                 reg_hi;
	logic [REG_IDX_W-1:0] reg_idx;
	word_t                reg_cur;
	word_t                old_b;
	word_t                new_b;
	word_t                reg_wval;
	word_t                ip_next;

	assign mask_s1 = width_mask(width_s1);
	assign reg_hi  = (width_s1 == WIDTH_BYTE) && rm_s1[2];
	assign reg_idx = reg_hi ? {1'b0, rm_s1[1:0]} : rm_s1;
	assign reg_cur = rf_q[reg_idx];

	always_comb begin
		logic [BANK_W-1:0] bsel;
		for (int k = 0; k < NUM_BANKS; k++) begin
			rd_byte[k] = fwd_s1[k] ? fwd_data_s1[k] : bk_rdata[k];
		end
		for (int i = 0; i < NUM_BANKS; i++) begin
			bsel = ea_s1[BANK_W-1:0] + BANK_W'(i);
			mem_word[8*i +: 8] = rd_byte[bsel];
		end
	end

	// invert
	always_comb begin
		if (inmem_s1) begin
			old_b = mem_word & mask_s1;
		end else if (reg_hi) begin
			old_b = {24'd0, reg_cur[15:8]};
		end else begin
			old_b = reg_cur & mask_s1;
		end
		new_b = old_b ^ mask_s1;
		if (reg_hi) begin
			reg_wval = {reg_cur[31:16], new_b[7:0], reg_cur[7:0]};
		end else begin
			reg_wval = (reg_cur & ~mask_s1) | new_b;
		end
	end

	// bank write enables and data, byte i of the operand goes to bank ea+i
	always_comb begin
		logic [BANK_W-1:0] boff;
		for (int k = 0; k < NUM_BANKS; k++) begin
			boff = BANK_W'(k) - ea_s1[BANK_W-1:0];
			b_we[k]    = 1'b0;
			b_wdata[k] = new_b[8*boff +: 8];
			if (b_adv && (op_s1 == OP_NOT) && inmem_s1) begin
				unique case (width_s1)
					WIDTH_BYTE: b_we[k] = (boff == BANK_W'(0));
					WIDTH_WORD: b_we[k] = (boff <= BANK_W'(1));
					default:    b_we[k] = 1'b1;
				endcase
			end else if (b_adv && (op_s1 == OP_LOAD_MEM)) begin
				b_we[k]    = (BANK_W'(k) == ea_s1[BANK_W-1:0]);
				b_wdata[k] = lval_s1[7:0];
			end
		end
	end

	// register file after this cycle's write-back
	always_comb begin
		for (int r = 0; r < NUM_REGS; r++) begin
			rf_d[r] = rf_q[r];
		end
		if (b_adv && (op_s1 == OP_NOT) && !inmem_s1) begin
			rf_d[reg_idx] = reg_wval;
		end else if (b_adv && (op_s1 == OP_LOAD_REG)) begin
			rf_d[lreg_s1] = lval_s1;
		end
	end

	assign ip_next = ip_q + 32'(ilen_s1);

	// architectural state and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				rf_q[r] <= '0;
			end
			ip_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else begin
			for (int r = 0; r < NUM_REGS; r++) begin
				rf_q[r] <= rf_d[r];
			end
			if (b_adv && (op_s1 == OP_NOT)) begin
				ip_q <= ip_next;
			end
			if (clr_busy_q) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
				if (clr_row_q == ROW_W'(MEM_ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (b_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload, with forwarding of bytes written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= in_op;
			width_s1 <= a_width;
			inmem_s1 <= (a_mod != MOD_REG);
			rm_s1    <= a_rm;
			ea_s1    <= a_ea;
			ilen_s1  <= a_ilen;
			lreg_s1  <= in_lreg;
			lval_s1  <= in_lval;
			for (int k = 0; k < NUM_BANKS; k++) begin
				row_s1[k]      <= a_row[k];
				fwd_s1[k]      <= b_we[k] && (row_s1[k] == a_row[k]);
				fwd_data_s1[k] <= b_wdata[k];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (b_adv && (op_s1 == OP_NOT)) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (b_adv && (op_s1 == OP_NOT)) begin
			m_axis_tdata <= {5'd0, ip_next, new_b, old_b, width_s1, inmem_s1,
				inmem_s1 ? ea_s1 : 16'd0};
		end
	end

endmodule

/* rtl/x86not16_chk.sv */
// port-level checker for the not-instruction block, bound to the top level
// depends on x86not16_pkg and x86_not_16bit_addressing_assert.svh
`timescale 1ns / 1ps
`include "x86_not_16bit_addressing_assert.svh"

module x86not16_chk
	import x86not16_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	// width_bit, size_prefix, modrm_byte, displacement, load_reg_index, load_value,
	// load_address, zero fill
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input logic [OP_W-1:0]        s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	// effective_address, operand_in_memory, operand_width, old_value, new_value, next_ip,
	// zero fill
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [15:0] out_ea;
	logic        out_inmem;
	logic [1:0]  out_width;
	word_t       out_old;
	word_t       out_new;
	word_t       out_ip;
	word_t       inv_bits;
	word_t       ip_delta;
	word_t       last_ip_q;
	logic        seen_q;

	assign out_ea    = m_axis_tdata[15:0];
	assign out_inmem = m_axis_tdata[16];
	assign out_width = m_axis_tdata[18:17];
	assign out_old   = m_axis_tdata[50:19];
	assign out_new   = m_axis_tdata[82:51];
	assign out_ip    = m_axis_tdata[114:83];
	assign inv_bits  = out_old ^ out_new;
	assign ip_delta  = out_ip - last_ip_q;

	// instruction pointer of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			last_ip_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			seen_q    <= 1'b1;
			last_ip_q <= out_ip;
		end
	end

	// a stalled result word holds
	`X86N_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// register operands report a zero address
	`X86N_ASSERT_NOW(a_reg_ea_zero, m_axis_tvalid && !out_inmem, out_ea == 16'd0)

	// new value is old value with exactly the operand-width bits flipped
	`X86N_ASSERT_NOW(a_inverted, m_axis_tvalid,
		((out_width == WIDTH_BYTE) && (inv_bits == 32'h0000_00ff)) ||
		((out_width == WIDTH_WORD) && (inv_bits == 32'h0000_ffff)) ||
		((out_width == WIDTH_DWORD) && (inv_bits == 32'hffff_ffff)))

	// each instruction is two to four bytes long
	`X86N_ASSERT_NOW(a_ip_step, m_axis_tvalid && seen_q,
		(ip_delta == 32'd2) || (ip_delta == 32'd3) || (ip_delta == 32'd4))

endmodule

bind x86_not_16bit_addressing x86not16_chk u_chk (.*);
